[rtl/bfa_pkg.sv]
// shared constants and controller/datapath interface types for the extent allocator
package bfa_pkg;

   localparam int SECTOR_BITS = 16384;
   localparam int WORD_BITS = 32;
   localparam int WORD_COUNT = SECTOR_BITS / WORD_BITS;
   localparam int ADDR_W = $clog2(WORD_COUNT);
   localparam int LANE_W = $clog2(WORD_BITS);

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE = 2'd1;
   localparam logic [1:0] MODE_MARK = 2'd2;

   localparam logic CSR_FIRST_DATA = 1'b0;
   localparam logic CSR_TOTAL = 1'b1;

   typedef struct packed {
      logic clear_en;
      logic load;
      logic scan_go;
      logic sweep_go;
      logic found;
      logic set_ok;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [1:0] mode;
      logic       empty;
      logic       stage_valid;
      logic       stage_last;
      logic       hit;
      logic       out_free;
   } status_type;

endpackage

[rtl/bfa_ctrl.sv]
// controller state machine: clearing pass, dispatch, scan, run update, response
module bfa_ctrl
   import bfa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_DISPATCH = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_SWEEP = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.mode == MODE_ALLOC) begin
               if (status.empty) state_in = ST_DONE;
               else begin
                  cmd.scan_go = 1'b1;
                  state_in = ST_SCAN;
               end
            end else if (status.mode == MODE_FREE || status.mode == MODE_MARK) begin
               cmd.set_ok = 1'b1;
               if (status.empty) state_in = ST_DONE;
               else begin
                  cmd.sweep_go = 1'b1;
                  state_in = ST_SWEEP;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (status.stage_valid && status.hit) begin
               cmd.found = 1'b1;
               state_in = ST_SWEEP;
            end else if (status.stage_valid && status.stage_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SWEEP: begin
            if (status.stage_valid && status.stage_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

[rtl/bfa_dp.sv]
// datapath: bitmap memory, word sweep, free-run search and result registers
module bfa_dp
   import bfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [14:0] csr_write_data,
   input  logic [1:0]  req_mode,
   input  logic [13:0] req_start_sector,
   input  logic [14:0] req_sector_count,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [13:0] rsp_extent_start,
   output logic        rsp_success,
   input  cmd_type     cmd,
   output status_type  status
);

   localparam logic [15:0] LIMIT = 16'(SECTOR_BITS);

   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [14:0] fds_ff, total_ff;
   logic [1:0]  mode_ff;
   logic [14:0] count_ff;
   logic [14:0] lo_ff, lo_in, hi_ff, hi_in;
   logic        set_ff;

   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              sweep_ff;
   logic              sweep_mark_ff;
   logic              stage_valid_ff, stage_last_ff;
   logic [ADDR_W-1:0] stage_addr_ff;
   logic [15:0]       carry_ff, carry_in;

   logic [13:0] res_start_ff;
   logic        res_ok_ff;
   logic        rsp_valid_ff;
   logic [13:0] rsp_start_ff;
   logic        rsp_ok_ff;

   logic [14:0]       end_sec;
   logic [15:0]       run_end;
   logic [ADDR_W-1:0] last_word;
   logic              go;
   logic [14:0]       base;
   logic [WORD_BITS-1:0] used, inrange, wdata;
   logic [15:0]       len [WORD_BITS];
   logic              any_used, hit;
   logic [LANE_W-1:0] last_used, hit_lane;
   logic [15:0]       pos, found16;
   logic [15:0]       found_end;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fds_ff <= 15'd9;
         total_ff <= 15'd16384;
      end else if (csr_write_en) begin
         if (csr_index == CSR_FIRST_DATA) fds_ff <= csr_write_data;
         else total_ff <= csr_write_data;
      end
   end

   assign end_sec = ({1'b0, total_ff} > LIMIT) ? LIMIT[14:0] : total_ff;
   assign run_end = 16'(req_start_sector) + 16'(req_sector_count);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.load) begin
         if (req_mode == MODE_ALLOC) begin
            lo_in = fds_ff;
            hi_in = end_sec;
         end else begin
            lo_in = 15'(req_start_sector);
            hi_in = (run_end > LIMIT) ? LIMIT[14:0] : run_end[14:0];
         end
      end else if (cmd.found) begin
         lo_in = found16[14:0];
         hi_in = found_end[14:0];
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.load) begin
         mode_ff <= req_mode;
         count_ff <= req_sector_count;
         set_ff <= (req_mode != MODE_FREE);
      end
   end

   assign last_word = ADDR_W'((hi_ff - 15'd1) >> LANE_W);
   assign go = cmd.scan_go | cmd.sweep_go | cmd.found;

   // word sweep with registered memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= 1'b0;
         stage_valid_ff <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.clear_en) clr_addr_ff <= clr_addr_ff + 1'b1;
         stage_valid_ff <= sweep_ff & ~go;
         if (go) begin
            sweep_ff <= 1'b1;
            rd_addr_ff <= ADDR_W'(lo_in >> LANE_W);
         end else if (sweep_ff) begin
            if (rd_addr_ff == last_word) sweep_ff <= 1'b0;
            else rd_addr_ff <= rd_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      stage_addr_ff <= rd_addr_ff;
      stage_last_ff <= (rd_addr_ff == last_word);
      carry_ff <= carry_in;
      rdata_ff <= mem[rd_addr_ff];
      if (cmd.clear_en) mem[clr_addr_ff] <= '0;
      else if (stage_valid_ff && mode_ff != MODE_ALLOC) mem[stage_addr_ff] <= wdata;
      else if (stage_valid_ff && mode_ff == MODE_ALLOC && set_ff && sweep_mark_ff)
         mem[stage_addr_ff] <= wdata;
   end

   // allocate uses the sweep twice: first to search, then to mark the run
   always_ff @(posedge clock) begin
      if (reset) sweep_mark_ff <= 1'b0;
      else if (cmd.scan_go) sweep_mark_ff <= 1'b0;
      else if (cmd.found) sweep_mark_ff <= 1'b1;
   end

   assign base = 15'({stage_addr_ff, {LANE_W{1'b0}}});

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         pos = 16'(base) + 16'(i);
         inrange[i] = (pos >= 16'(lo_ff)) && (pos < 16'(hi_ff));
      end
      used = rdata_ff | ~inrange;
      wdata = set_ff ? (rdata_ff | inrange) : (rdata_ff & ~inrange);
   end

   always_comb begin
      any_used = 1'b0;
      last_used = '0;
      hit = 1'b0;
      hit_lane = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (used[i]) begin
            any_used = 1'b1;
            last_used = LANE_W'(i);
         end
         if (used[i]) len[i] = '0;
         else if (any_used) len[i] = 16'(i) - 16'(last_used);
         else len[i] = carry_ff + 16'(i) + 16'd1;
         if (!hit && !used[i] && len[i] >= 16'(count_ff)) begin
            hit = 1'b1;
            hit_lane = LANE_W'(i);
         end
      end
      found16 = 16'(base) + 16'(hit_lane) + 16'd1 - 16'(count_ff);
      found_end = found16 + 16'(count_ff);
      if (cmd.scan_go) carry_in = '0;
      else if (stage_valid_ff) carry_in = len[WORD_BITS-1];
      else carry_in = carry_ff;
   end

   // result and output registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_start_ff <= '0;
         res_ok_ff <= 1'b0;
      end else if (cmd.set_ok) begin
         res_ok_ff <= 1'b1;
      end else if (cmd.found) begin
         res_ok_ff <= 1'b1;
         res_start_ff <= found16[13:0];
      end
      if (cmd.publish) begin
         rsp_start_ff <= res_start_ff;
         rsp_ok_ff <= res_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.publish) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_extent_start = rsp_start_ff;
   assign rsp_success = rsp_ok_ff;

   always_comb begin
      status.clear_last = (clr_addr_ff == ADDR_W'(WORD_COUNT - 1));
      status.mode = mode_ff;
      status.empty = (count_ff == '0) || (lo_ff >= hi_ff);
      status.stage_valid = stage_valid_ff;
      status.stage_last = stage_last_ff;
      status.hit = hit;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

endmodule

[rtl/bitmap_first_fit_extent_allocator.sv]
// top level of the bitmap first-fit extent allocator
// one request word in on req_, one response word out on rsp_ per request.
// mode 0 allocates the first free run of req_sector_count sectors between
// first_data_sector and min(sector_total, 16384) and marks it used; mode 1
// frees and mode 2 marks the run at req_start_sector. rsp_success is 0 and
// rsp_extent_start 0 on a failed allocate or an unknown mode.
// an allocate scans one 32-bit word per cycle through the single bitmap read
// port, up to 512 words, then updates the words of the found run; free and
// mark update each word of the run in turn. req_stall is high while a request
// is being worked on.
// after reset the bitmap is cleared one word per cycle, all 512 words, with
// req_stall high; csr writes are taken at any time.
// a finished response sits in an output register; the next request is
// accepted while rsp_stall holds it, and its own result waits until the
// previous response is taken.
module bitmap_first_fit_extent_allocator
   import bfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [14:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [13:0] req_start_sector,
   input  logic [14:0] req_sector_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_extent_start,
   output logic        rsp_success
);

   cmd_type    cmd;
   status_type status;

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bfa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_mode         (req_mode),
      .req_start_sector (req_start_sector),
      .req_sector_count (req_sector_count),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_extent_start (rsp_extent_start),
      .rsp_success      (rsp_success),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

[rtl/bfa_checker.sv]
// port-level checks for the extent allocator, bound to the top level
module bfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [13:0] rsp_extent_start,
   input logic        rsp_success
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && req_stall)
      else $error("busy or response right after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken without going busy");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_success |-> rsp_extent_start == 14'd0)
      else $error("failed response with nonzero start");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_extent_start) && $stable(rsp_success))
      else $error("stalled response word changed");

endmodule

bind bitmap_first_fit_extent_allocator bfa_checker u_bfa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_extent_start (rsp_extent_start),
   .rsp_success      (rsp_success)
);

[tb/bitmap_first_fit_extent_allocator_tb.sv]
// self-checking testbench for the bitmap first-fit extent allocator
`timescale 1ns / 1ps

module bitmap_first_fit_extent_allocator_tb;
   import bfa_pkg::*;

   localparam logic [1:0] MODE_UNKNOWN = 2'd3;
   localparam int STALL_LIMIT = 30000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [13:0] extent_start;
      logic        success;
   } extent_result_type;

   class extent_scoreboard;
      bit [SECTOR_BITS-1:0] used_map;
      int unsigned first_sector;
      int unsigned sector_total;
      extent_result_type pending_results[$];
      int errors;

      function new();
         used_map = '0;
         first_sector = 9;
         sector_total = 16384;
         errors = 0;
      endfunction

      function void write_reg(logic idx, logic [14:0] value);
         if (idx == CSR_FIRST_DATA) begin
            first_sector = 32'(value);
         end else begin
            sector_total = 32'(value);
         end
      endfunction

      function void set_run(int unsigned first, int unsigned count, bit value);
         int unsigned s;
         for (int unsigned i = 0; i < count; i++) begin
            s = first + i;
            if (s >= SECTOR_BITS) break;
            used_map[s] = value;
         end
      endfunction

      function void note_request(logic [1:0] mode, logic [13:0] start, logic [14:0] count);
         extent_result_type res;
         int unsigned search_end;
         int unsigned run_first;
         int unsigned run_len;
         res = '0;
         run_first = 0;
         run_len = 0;
         case (mode)
            MODE_ALLOC: begin
               search_end = (sector_total > SECTOR_BITS) ? SECTOR_BITS : sector_total;
               if (count != 0) begin
                  for (int unsigned s = first_sector; s < search_end; s++) begin
                     if (used_map[s]) begin
                        run_len = 0;
                        continue;
                     end
                     if (run_len == 0) run_first = s;
                     run_len++;
                     if (run_len == count) begin
                        set_run(run_first, 32'(count), 1'b1);
                        res.extent_start = run_first[13:0];
                        res.success = 1'b1;
                        break;
                     end
                  end
               end
            end
            MODE_FREE: begin
               set_run(32'(start), 32'(count), 1'b0);
               res.success = 1'b1;
            end
            MODE_MARK: begin
               set_run(32'(start), 32'(count), 1'b1);
               res.success = 1'b1;
            end
            default: begin
            end
         endcase
         pending_results.push_back(res);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [13:0] extent_start, logic success);
         extent_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected word extent_start=%0d success=%0b",
                             extent_start, success));
         end else begin
            want = pending_results.pop_front();
            if (extent_start !== want.extent_start)
               report($sformatf("extent_start got %0d want %0d", extent_start,
                                want.extent_start));
            if (success !== want.success)
               report($sformatf("success got %0b want %0b", success, want.success));
         end
      endtask

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [14:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [13:0] req_start_sector;
   logic [14:0] req_sector_count;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [13:0] rsp_extent_start;
   logic        rsp_success;

   extent_scoreboard sb = new();
   int items_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_style = 0;
   int stall_cycle = 0;
   int hold_left = 0;
   bit hold_done = 0;

   bitmap_first_fit_extent_allocator dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_start_sector(req_start_sector),
      .req_sector_count(req_sector_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_extent_start(rsp_extent_start),
      .rsp_success(rsp_success)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // accepted words on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_extent_start, rsp_success);
         if (req_valid && !req_stall) sb.note_request(req_mode, req_start_sector, req_sector_count);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_sent >= 400) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         if (stall_cycle == 0) stall_style <= $urandom_range(2, 0);
         stall_cycle <= (stall_cycle + 1) % 300;
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(99, 0) < 30);
            default: rsp_stall <= ($urandom_range(99, 0) < 75);
         endcase
      end
   end

   task send_word(logic [1:0] mode, logic [13:0] start, logic [14:0] count);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(24, 1);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_start_sector <= start;
      req_sector_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_csr(logic idx, logic [14:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      sb.write_reg(idx, value);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task random_word();
      int pick;
      logic [14:0] count;
      logic [13:0] start;
      int unsigned lo;
      int unsigned hi;
      pick = $urandom_range(99, 0);
      lo = (sb.first_sector < SECTOR_BITS) ? sb.first_sector : 0;
      hi = (sb.sector_total > lo && sb.sector_total <= SECTOR_BITS) ? sb.sector_total - 1
                                                                    : SECTOR_BITS - 1;
      if (hi < lo) hi = lo;
      start = 14'($urandom_range(hi, lo));
      if (pick < 45) begin
         case ($urandom_range(19, 0))
            0: count = 15'($urandom_range(32767, 0));
            1, 2: count = 15'($urandom_range(1200, 64));
            default: count = 15'($urandom_range(48, 1));
         endcase
         send_word(MODE_ALLOC, 14'($urandom_range(16383, 0)), count);
      end else if (pick < 75) begin
         count = ($urandom_range(15, 0) == 0) ? 15'($urandom_range(32767, 0))
                                              : 15'($urandom_range(160, 0));
         send_word(MODE_FREE, start, count);
      end else if (pick < 88) begin
         send_word(MODE_MARK, start, 15'($urandom_range(64, 0)));
      end else if (pick < 96) begin
         send_word(2'($urandom_range(2, 1)), 14'($urandom_range(16383, 0)),
                   15'($urandom_range(32767, 0)));
      end else begin
         send_word(MODE_UNKNOWN, 14'($urandom_range(16383, 0)),
                   15'($urandom_range(32767, 0)));
      end
   endtask

   task run_phase(logic [14:0] first, logic [14:0] total, int count);
      drain();
      write_csr(CSR_FIRST_DATA, first);
      write_csr(CSR_TOTAL, total);
      send_word(MODE_FREE, 14'd0, 15'd16384);
      send_word(MODE_ALLOC, 14'd0, 15'd5);
      for (int i = 0; i < count; i++) random_word();
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_mode = MODE_ALLOC;
      req_start_sector = '0;
      req_sector_count = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(MODE_ALLOC, 14'd0, 15'd0);
      send_word(MODE_ALLOC, 14'd0, 15'd1);
      send_word(MODE_ALLOC, 14'd0, 15'd40);
      send_word(MODE_MARK, 14'd0, 15'd16384);
      send_word(MODE_ALLOC, 14'd0, 15'd1);
      send_word(MODE_FREE, 14'd16383, 15'd32767);
      send_word(MODE_ALLOC, 14'd0, 15'd1);
      send_word(MODE_ALLOC, 14'd0, 15'd1);
      send_word(MODE_FREE, 14'd100, 15'd0);
      send_word(MODE_MARK, 14'd16380, 15'd0);
      send_word(MODE_UNKNOWN, 14'h3FFF, 15'h7FFF);
      send_word(MODE_FREE, 14'd0, 15'd16384);
      send_word(MODE_ALLOC, 14'd0, 15'd16384);
      send_word(MODE_ALLOC, 14'd0, 15'd16375);
      send_word(MODE_ALLOC, 14'd0, 15'd1);
      send_word(MODE_FREE, 14'd64, 15'd33);
      send_word(MODE_ALLOC, 14'd0, 15'd33);
      send_word(MODE_MARK, 14'h2AAA, 15'h5555);
      send_word(MODE_FREE, 14'h1555, 15'h2AAA);
      send_word(MODE_ALLOC, 14'd0, 15'h7FFF);

      run_phase(15'd0, 15'd16384, 140);
      run_phase(15'd100, 15'd3000, 140);
      run_phase(15'd16384, 15'd16384, 60);
      run_phase(15'd0, 15'd0, 60);
      run_phase(15'd3, 15'h7FFF, 140);
      run_phase(15'h7FFF, 15'd5, 60);
      run_phase(15'd1000, 15'd1200, 140);
      run_phase(15'd0, 15'd64, 140);
      run_phase(15'd9, 15'd16384, 250);

      drain();
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[bitmap_first_fit_extent_allocator.f]
rtl/bfa_pkg.sv
rtl/bfa_ctrl.sv
rtl/bfa_dp.sv
rtl/bitmap_first_fit_extent_allocator.sv
rtl/bfa_checker.sv
tb/bitmap_first_fit_extent_allocator_tb.sv
